FILE: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is high
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds through reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/lswc_pkg.sv
// Types, constants and helper functions of the line segment window clipper
package lswc_pkg;

  // external coordinate width and edge move limit
  localparam int COORD_WIDTH    = 16;
  localparam int MAX_ITERATIONS = 8;

  // quotient is kept modulo 2**QUO_WIDTH
  localparam int QUO_WIDTH = 40;

  // internal coordinate width: each move adds less than 2**QUO_WIDTH
  localparam int CRD_W  = QUO_WIDTH + $clog2(MAX_ITERATIONS) + 2;
  localparam int DIFF_W = CRD_W + 1;
  localparam int MAG_W  = CRD_W;
  localparam int CNT_W  = $clog2(2 * MAG_W);
  localparam int MOVE_W = $clog2(MAX_ITERATIONS + 1);

  // register port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_X_MAX = 2'd1;
  localparam logic [1:0] REG_Y_MIN = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  // outcode bit positions
  localparam int CODE_LEFT   = 0;
  localparam int CODE_RIGHT  = 1;
  localparam int CODE_BOTTOM = 2;
  localparam int CODE_TOP    = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [CRD_W-1:0]       crd_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic [MAG_W-1:0]              mag_t;
  typedef logic [QUO_WIDTH-1:0]          quo_t;
  typedef logic [3:0]                    code_t;

  // request to the multiply-divide unit: trunc(a * b / den)
  typedef struct packed {
    logic start;
    mag_t a;
    mag_t b;
    mag_t den;
  } mdu_req_t;

  typedef struct packed {
    logic done;
    quo_t quo;
  } mdu_rsp_t;

  // region code of a point against the window
  function automatic code_t outcode(crd_t x, crd_t y, coord_t xmin, coord_t xmax,
                                    coord_t ymin, coord_t ymax);
    code_t c;
    c = '0;
    if (x < CRD_W'(xmin)) c[CODE_LEFT] = 1'b1;
    else if (x > CRD_W'(xmax)) c[CODE_RIGHT] = 1'b1;
    if (y < CRD_W'(ymin)) c[CODE_BOTTOM] = 1'b1;
    else if (y > CRD_W'(ymax)) c[CODE_TOP] = 1'b1;
    return c;
  endfunction

  // absolute value of a difference
  function automatic mag_t magnitude(diff_t v);
    diff_t t;
    t = v[DIFF_W-1] ? -v : v;
    return t[MAG_W-1:0];
  endfunction

endpackage

FILE: design/lswc_mdu.sv
// Shift-add multiplier and restoring divider around one shared adder
module lswc_mdu (
  input  logic               clk,
  input  logic               rst,
  input  lswc_pkg::mdu_req_t req,
  output lswc_pkg::mdu_rsp_t rsp
);
  import lswc_pkg::*;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_DONE} md_state_t;

  md_state_t          state;
  logic [CNT_W-1:0]   cnt;
  logic [2*MAG_W:0]   prod;      // {high accumulator, multiplier / numerator}
  mag_t               mcand;
  mag_t               den;
  mag_t               rem;
  quo_t               quo;
  logic               den_zero;

  logic [MAG_W:0]     add_a;
  logic [MAG_W:0]     add_b;
  logic               add_sub;
  logic [MAG_W+1:0]   add_res;

  // shared adder: accumulate in multiply, trial subtract in divide
  always_comb begin
    if (state == MD_DIV) begin
      add_a   = {rem, prod[2*MAG_W-1]};
      add_b   = {1'b0, den};
      add_sub = 1'b1;
    end else begin
      add_a   = prod[2*MAG_W:MAG_W];
      add_b   = prod[0] ? {1'b0, mcand} : '0;
      add_sub = 1'b0;
    end
    add_res = {1'b0, add_a} + {1'b0, add_b ^ {(MAG_W+1){add_sub}}}
            + {{(MAG_W+1){1'b0}}, add_sub};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
    end else begin
      unique case (state)
        MD_IDLE: begin
          if (req.start) begin
            prod     <= {{(MAG_W+1){1'b0}}, req.b};
            mcand    <= req.a;
            den      <= req.den;
            den_zero <= (req.den == '0);
            rem      <= '0;
            quo      <= '0;
            cnt      <= '0;
            state    <= MD_MUL;
          end
        end
        MD_MUL: begin
          prod <= {1'b0, add_res[MAG_W:0], prod[MAG_W-1:1]};
          if (cnt == CNT_W'(MAG_W - 1)) begin
            cnt   <= '0;
            state <= MD_DIV;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        MD_DIV: begin
          // carry out set means the trial subtract did not borrow
          prod <= {prod[2*MAG_W-1:0], 1'b0};
          rem  <= add_res[MAG_W+1] ? add_res[MAG_W-1:0] : add_a[MAG_W-1:0];
          quo  <= {quo[QUO_WIDTH-2:0], add_res[MAG_W+1]};
          if (cnt == CNT_W'(2 * MAG_W - 1)) begin
            state <= MD_DONE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        MD_DONE: state <= MD_IDLE;
        default: state <= MD_IDLE;
      endcase
    end
  end

  // a zero divisor gives a zero quotient
  assign rsp.done = (state == MD_DONE);
  assign rsp.quo  = den_zero ? '0 : quo;

endmodule

FILE: design/line_segment_window_clipper.sv
// Cohen-Sutherland line segment clipper against a register-held window
//
//  channel   handshake                   beat contents
//  segment   seg_valid / seg_ready       start_x, start_y, end_x, end_y
//  result    res_valid / res_ready       accepted, clipped_start_x .. clipped_end_y
//  config    APB psel/penable/pwrite     window_x_min, _x_max, _y_min, _y_max at 0/4/8/12
//
// One segment at a time; a segment takes at most MAX_ITERATIONS edge moves.
// Each move costs a shift-add multiply and a restoring divide
// in the shared adder of lswc_mdu, plus outcode check, set-up and hand-back cycles.
// Reset is synchronous; it clears the sequencer, the result valid and the window registers.
// The result sits in an output register; a stalled result holds the block in its
// final state only once the next segment has been worked through.
module line_segment_window_clipper (
  input  logic                          clk,
  input  logic                          rst,
  // segment channel
  input  logic                          seg_valid,
  output logic                          seg_ready,
  input  lswc_pkg::coord_t              start_x,
  input  lswc_pkg::coord_t              start_y,
  input  lswc_pkg::coord_t              end_x,
  input  lswc_pkg::coord_t              end_y,
  // result channel
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          accepted,
  output lswc_pkg::coord_t              clipped_start_x,
  output lswc_pkg::coord_t              clipped_start_y,
  output lswc_pkg::coord_t              clipped_end_x,
  output lswc_pkg::coord_t              clipped_end_y,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lswc_pkg::APB_AW-1:0]   paddr,
  input  logic [lswc_pkg::APB_DW-1:0]   pwdata,
  output logic [lswc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import lswc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SETUP, ST_CALC, ST_FINISH
  } state_t;

  typedef enum logic [1:0] {SIDE_TOP, SIDE_BOTTOM, SIDE_RIGHT, SIDE_LEFT} side_t;

  // window registers
  coord_t wx_min, wx_max, wy_min, wy_max;

  state_t             state;
  crd_t               x1, y1, x2, y2;
  logic [MOVE_W-1:0]  moves;
  logic               acc;
  side_t              side;
  logic               first;
  crd_t               base;
  logic               neg;
  crd_t               side_val;

  code_t              c1, c2, co;
  side_t              side_sel;
  logic               vert;
  coord_t             side_win;
  crd_t               pa1, pa2, pb1, pb2;
  diff_t              d, n, q;
  crd_t               isect;
  mdu_req_t           req;
  mdu_rsp_t           rsp;

  logic [1:0]         reg_idx;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      wx_min <= '0;
      wx_max <= '0;
      wy_min <= '0;
      wy_max <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_X_MIN: wx_min <= pwdata[COORD_WIDTH-1:0];
        REG_X_MAX: wx_max <= pwdata[COORD_WIDTH-1:0];
        REG_Y_MIN: wy_min <= pwdata[COORD_WIDTH-1:0];
        REG_Y_MAX: wy_max <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_MIN: prdata = APB_DW'(wx_min);
      REG_X_MAX: prdata = APB_DW'(wx_max);
      REG_Y_MIN: prdata = APB_DW'(wy_min);
      REG_Y_MAX: prdata = APB_DW'(wy_max);
      default:   prdata = '0;
    endcase
  end

  // outcodes and choice of the edge to clip against
  always_comb begin
    c1 = outcode(x1, y1, wx_min, wx_max, wy_min, wy_max);
    c2 = outcode(x2, y2, wx_min, wx_max, wy_min, wy_max);
    co = (c1 != '0) ? c1 : c2;
    priority if (co[CODE_TOP])    side_sel = SIDE_TOP;
    else if (co[CODE_BOTTOM])     side_sel = SIDE_BOTTOM;
    else if (co[CODE_RIGHT])      side_sel = SIDE_RIGHT;
    else                          side_sel = SIDE_LEFT;
  end

  // operands of the edge intersection
  always_comb begin
    vert = (side == SIDE_TOP) || (side == SIDE_BOTTOM);
    unique case (side)
      SIDE_TOP:    side_win = wy_max;
      SIDE_BOTTOM: side_win = wy_min;
      SIDE_RIGHT:  side_win = wx_max;
      SIDE_LEFT:   side_win = wx_min;
      default:     side_win = wx_min;
    endcase
    pa1 = vert ? x1 : y1;
    pa2 = vert ? x2 : y2;
    pb1 = vert ? y1 : x1;
    pb2 = vert ? y2 : x2;
    d   = DIFF_W'(pa2) - DIFF_W'(pa1);
    n   = DIFF_W'(side_win) - DIFF_W'(pb1);
    q   = DIFF_W'(pb2) - DIFF_W'(pb1);
  end

  assign req.start = (state == ST_SETUP);
  assign req.a     = magnitude(d);
  assign req.b     = magnitude(n);
  assign req.den   = magnitude(q);

  lswc_mdu u_mdu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // moved coordinate: base plus or minus the quotient
  always_comb begin
    if (neg) isect = base - CRD_W'(rsp.quo);
    else     isect = base + CRD_W'(rsp.quo);
  end

  assign seg_ready = (state == ST_IDLE);

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      // beat taken; in ST_FINISH the next result reloads it instead
      if (res_valid && res_ready && state != ST_FINISH) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (seg_valid) begin
            x1    <= CRD_W'(start_x);
            y1    <= CRD_W'(start_y);
            x2    <= CRD_W'(end_x);
            y2    <= CRD_W'(end_y);
            moves <= '0;
            acc   <= 1'b0;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          priority if (c1 == '0 && c2 == '0) begin
            acc   <= 1'b1;
            state <= ST_FINISH;
          end else if ((c1 & c2) != '0 || moves == MOVE_W'(MAX_ITERATIONS)) begin
            state <= ST_FINISH;
          end else begin
            moves <= moves + MOVE_W'(1);
            side  <= side_sel;
            first <= (c1 != '0);
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          base     <= pa1;
          neg      <= d[DIFF_W-1] ^ n[DIFF_W-1] ^ q[DIFF_W-1];
          side_val <= CRD_W'(side_win);
          state    <= ST_CALC;
        end
        ST_CALC: begin
          if (rsp.done) begin
            if (first) begin
              x1 <= vert ? isect : side_val;
              y1 <= vert ? side_val : isect;
            end else begin
              x2 <= vert ? isect : side_val;
              y2 <= vert ? side_val : isect;
            end
            state <= ST_CHECK;
          end
        end
        ST_FINISH: begin
          if (!res_valid || res_ready) begin
            accepted        <= acc;
            clipped_start_x <= x1[COORD_WIDTH-1:0];
            clipped_start_y <= y1[COORD_WIDTH-1:0];
            clipped_end_x   <= x2[COORD_WIDTH-1:0];
            clipped_end_y   <= y2[COORD_WIDTH-1:0];
            res_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/lswc_checker.sv
// Port-level checks of the clipper, bound to the top level
`include "assert_macros.svh"

module lswc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        seg_valid,
  input logic                        seg_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        accepted,
  input lswc_pkg::coord_t            clipped_start_x,
  input lswc_pkg::coord_t            clipped_start_y,
  input lswc_pkg::coord_t            clipped_end_x,
  input lswc_pkg::coord_t            clipped_end_y,
  input logic                        pready
);

  // stalled result beat holds
  property p_result_hold;
    res_valid && !res_ready |=> res_valid && $stable(accepted)
      && $stable(clipped_start_x) && $stable(clipped_start_y)
      && $stable(clipped_end_x) && $stable(clipped_end_y);
  endproperty

  // register port never stalls
  `ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")

  // reset leaves no result pending and the segment side open
  `ASSERT_ALWAYS(a_reset_state, clk, rst |=> !res_valid && seg_ready, "bad state after reset")

  // one segment at a time: no new beat straight after an accepted one
  `ASSERT_RST(a_one_at_a_time, clk, rst, seg_valid && seg_ready |=> !seg_ready, "ready after accept")

  // a fresh result only follows clipping work, never an idle cycle
  `ASSERT_RST(a_result_from_work, clk, rst, $rose(res_valid) |-> !$past(seg_ready), "result from idle")

  `ASSERT_RST(a_result_hold, clk, rst, p_result_hold, "result changed while stalled")

endmodule

bind line_segment_window_clipper lswc_checker u_lswc_checker (.*);
